/* hdl/ctwp_pkg.sv */
// Shared types, constants and helpers of the convolution tile window planner.
package ctwp_pkg;

  localparam int IdxW    = 20;
  localparam int DimW    = 11;
  localparam int CoordW  = 10;
  localparam int TileW   = 5;
  localparam int DivStep = 4;
  localparam int DivStages = IdxW / DivStep;
  localparam int RecipW  = 17;
  localparam int RecipShift = 16;

  localparam logic [DimW-1:0]  MaxDim  = 11'd1024;
  localparam logic [TileW-1:0] MaxTile = 5'd16;

  // floor(2^16 / n) for tile sizes 1 to 16; other entries are zero.
  localparam logic [RecipW-1:0] RecipTab [32] = '{
    17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922,
    17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,
    17'd4681,  17'd4369,  17'd4096,  17'd0,     17'd0,     17'd0,     17'd0,
    17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,
    17'd0,     17'd0,     17'd0,     17'd0
  };

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StHint   = 2'd1,
    StGrid   = 2'd2,
    StWindow = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RegOutWidth  = 3'd0,
    RegOutHeight = 3'd1,
    RegInWidth   = 3'd2,
    RegInHeight  = 3'd3,
    RegTileHint  = 3'd4,
    RegStride    = 3'd5,
    RegKernel    = 3'd6,
    RegPadding   = 3'd7
  } reg_idx_t;

  // One stage of the tile index divider: dividend bits shift out of nq at the
  // top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [IdxW-1:0] nq;
    logic [DimW-1:0] rem;
    logic [DimW-1:0] den;
    logic [DimW-1:0] rows;
  } div_t;

  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
    return (v > MaxDim) ? MaxDim : v;
  endfunction

endpackage

/* hdl/ctwp_div.sv */
// Pipelined restoring divider that splits the tile index into row and column.
module ctwp_div (
  input  logic                                clk,
  input  logic [ctwp_pkg::DivStages-1:0]      en,
  input  ctwp_pkg::div_t                      d_in,
  output ctwp_pkg::div_t                      d_out
);
  import ctwp_pkg::*;

  div_t st [DivStages];

  function automatic div_t div_stage(input div_t d);
    div_t r;
    logic [DimW:0] trial;
    logic [DimW:0] diff;
    r = d;
    for (int b = 0; b < DivStep; b++) begin
      trial = {r.rem, r.nq[IdxW-1]};
      diff  = trial - {1'b0, r.den};
      if (trial >= {1'b0, r.den}) begin
        r.rem = diff[DimW-1:0];
        r.nq  = {r.nq[IdxW-2:0], 1'b1};
      end else begin
        r.rem = trial[DimW-1:0];
        r.nq  = {r.nq[IdxW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[k]) begin
          st[k] <= div_stage(d_in);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[k]) begin
          st[k] <= div_stage(st[k-1]);
        end
      end
    end
  end

  assign d_out = st[DivStages-1];

endmodule

/* hdl/conv_tile_window_planner.sv */
// Top level of the convolution tile window planner: registers, pipeline, outputs.
//
// Usage: program the layer geometry over the APB-style port while no word is in
// flight, then send tile numbers on the input channel (in_valid, in_stall,
// tile_number). For each accepted word one result word leaves on the output
// channel (out_valid, out_stall, status and the tile and window fields).
// The pipeline has eleven register stages: stage 1, stage 2, the five divider
// stages, E1, E2, E3 and the output register. One word is taken per cycle while
// out_stall does not hold the pipeline; the rate is set by the five-stage index
// divider, which retires four quotient bits per stage.
// Each stage holds its own valid bit. When out_stall is high the output word
// holds, and stages behind it keep moving until they close up on it; in_stall
// rises only when every stage is full. No word is lost or repeated.
// Reset clears all valid bits and returns the registers to their defaults:
// 1x1 tensors, tile hint 0 (16x16 tiles), stride 1, kernel 1, no padding.
// An error status forces every other output field of that word to zero.
module conv_tile_window_planner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ctwp_pkg::IdxW-1:0]     tile_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [ctwp_pkg::CoordW-1:0]   out_x,
  output logic [ctwp_pkg::CoordW-1:0]   out_y,
  output logic [ctwp_pkg::TileW-1:0]    out_w,
  output logic [ctwp_pkg::TileW-1:0]    out_h,
  output logic [ctwp_pkg::CoordW-1:0]   in_x,
  output logic [ctwp_pkg::CoordW-1:0]   in_y,
  output logic [ctwp_pkg::DimW-1:0]     in_w,
  output logic [ctwp_pkg::DimW-1:0]     in_h
);
  import ctwp_pkg::*;

  localparam int StS1  = 0;
  localparam int StS2  = 1;
  localparam int StDiv = 2;
  localparam int StE1  = StDiv + DivStages;
  localparam int StE2  = StE1 + 1;
  localparam int StE3  = StE2 + 1;
  localparam int StOut = StE3 + 1;
  localparam int NStg  = StOut + 1;

  // Configuration registers.
  logic [DimW-1:0] out_width, out_height, in_width, in_height;
  logic [9:0]      tile_hint;
  logic [1:0]      stride, kernel_size, padding;

  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width   <= 11'd1;
      out_height  <= 11'd1;
      in_width    <= 11'd1;
      in_height   <= 11'd1;
      tile_hint   <= '0;
      stride      <= 2'd1;
      kernel_size <= 2'd1;
      padding     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegOutWidth:  out_width   <= pwdata[DimW-1:0];
        RegOutHeight: out_height  <= pwdata[DimW-1:0];
        RegInWidth:   in_width    <= pwdata[DimW-1:0];
        RegInHeight:  in_height   <= pwdata[DimW-1:0];
        RegTileHint:  tile_hint   <= pwdata[9:0];
        RegStride:    stride      <= pwdata[1:0];
        RegKernel:    kernel_size <= pwdata[1:0];
        RegPadding:   padding     <= pwdata[1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegOutWidth:  prdata = {21'b0, out_width};
      RegOutHeight: prdata = {21'b0, out_height};
      RegInWidth:   prdata = {21'b0, in_width};
      RegInHeight:  prdata = {21'b0, in_height};
      RegTileHint:  prdata = {22'b0, tile_hint};
      RegStride:    prdata = {30'b0, stride};
      RegKernel:    prdata = {30'b0, kernel_size};
      RegPadding:   prdata = {30'b0, padding};
      default:      prdata = '0;
    endcase
  end

  // Geometry derived from the registers. The user must change the registers only
  // while the pipeline is empty (the block does not enforce this), so every stage may use these directly.
  logic [TileW-1:0] hint_w, hint_h, tw, th;
  logic             hint_bad;
  logic [DimW-1:0]  ow, oh, iw, ih;
  logic [DimW:0]    nw_sum, nh_sum;
  logic [DimW-1:0]  nw, nh;

  always_comb begin
    hint_w   = tile_hint[4:0];
    hint_h   = tile_hint[9:5];
    tw       = (hint_w == '0) ? MaxTile : hint_w;
    th       = (hint_h == '0) ? MaxTile : hint_h;
    hint_bad = (tw > MaxTile) || (th > MaxTile);
    ow       = sat_dim(out_width);
    oh       = sat_dim(out_height);
    iw       = sat_dim(in_width);
    ih       = sat_dim(in_height);
    nw_sum   = {1'b0, ow} + {7'b0, tw} - 12'd1;
    nh_sum   = {1'b0, oh} + {7'b0, th} - 12'd1;
    nw       = nw_sum[DimW-1:0];
    nh       = nh_sum[DimW-1:0];
  end

  // Stage valid bits and the enable chain.
  logic [NStg-1:0] v, en;

  always_comb begin
    en[StOut] = !v[StOut] || !out_stall;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~en) | ({v[NStg-2:0], in_valid} & en);
    end
  end

  assign in_stall  = !en[StS1];
  assign out_valid = v[StOut];

  // Stage 1: reciprocal estimate of the tile grid size.
  logic [IdxW-1:0] s1_idx;
  logic [DimW-1:0] s1_est_w, s1_est_h;
  logic [27:0]     prod_w, prod_h;

  always_comb begin
    prod_w = {17'b0, nw} * {11'b0, RecipTab[tw]};
    prod_h = {17'b0, nh} * {11'b0, RecipTab[th]};
  end

  always_ff @(posedge clk) begin
    if (en[StS1]) begin
      s1_idx   <= tile_number;
      s1_est_w <= prod_w[RecipShift+DimW-1:RecipShift];
      s1_est_h <= prod_h[RecipShift+DimW-1:RecipShift];
    end
  end

  // Stage 2: the estimate is at most one short; fix it with one compare.
  logic [15:0]     chk_w, chk_h, res_w, res_h;
  logic [DimW-1:0] cols, rows;
  logic [IdxW-1:0] s2_idx;
  logic [DimW-1:0] s2_cols, s2_rows;

  always_comb begin
    chk_w = {5'b0, s1_est_w} * {11'b0, tw};
    chk_h = {5'b0, s1_est_h} * {11'b0, th};
    res_w = {5'b0, nw} - chk_w;
    res_h = {5'b0, nh} - chk_h;
    cols  = (res_w >= {11'b0, tw}) ? s1_est_w + 11'd1 : s1_est_w;
    rows  = (res_h >= {11'b0, th}) ? s1_est_h + 11'd1 : s1_est_h;
  end

  always_ff @(posedge clk) begin
    if (en[StS2]) begin
      s2_idx  <= s1_idx;
      s2_cols <= cols;
      s2_rows <= rows;
    end
  end

  // Divider stages: tile row = index / cols, tile column = index % cols.
  div_t div_in, div_out;

  always_comb begin
    div_in.nq   = s2_idx;
    div_in.rem  = '0;
    div_in.den  = s2_cols;
    div_in.rows = s2_rows;
  end

  ctwp_div u_div (
    .clk   (clk),
    .en    (en[StDiv +: DivStages]),
    .d_in  (div_in),
    .d_out (div_out)
  );

  // Stage E1: grid check and tile origin.
  logic              grid_err;
  logic [14:0]       ox_prod, oy_prod;
  logic              e1_grid_err;
  logic [CoordW-1:0] e1_ox, e1_oy;

  always_comb begin
    grid_err = (div_out.den == '0) || (div_out.nq >= IdxW'(div_out.rows));
    ox_prod  = {5'b0, div_out.rem[CoordW-1:0]} * {10'b0, tw};
    oy_prod  = {5'b0, div_out.nq[CoordW-1:0]} * {10'b0, th};
  end

  always_ff @(posedge clk) begin
    if (en[StE1]) begin
      e1_grid_err <= grid_err;
      e1_ox       <= ox_prod[CoordW-1:0];
      e1_oy       <= oy_prod[CoordW-1:0];
    end
  end

  // Stage E2: trim tiles on the right and bottom edges.
  logic [DimW-1:0]   left_w, left_h;
  logic [TileW-1:0]  otw, oth;
  logic              e2_grid_err;
  logic [CoordW-1:0] e2_ox, e2_oy;
  logic [TileW-1:0]  e2_otw, e2_oth;

  always_comb begin
    left_w = ow - {1'b0, e1_ox};
    left_h = oh - {1'b0, e1_oy};
    otw    = (left_w < {6'b0, tw}) ? left_w[TileW-1:0] : tw;
    oth    = (left_h < {6'b0, th}) ? left_h[TileW-1:0] : th;
  end

  always_ff @(posedge clk) begin
    if (en[StE2]) begin
      e2_grid_err <= e1_grid_err;
      e2_ox       <= e1_ox;
      e2_oy       <= e1_oy;
      e2_otw      <= otw;
      e2_oth      <= oth;
    end
  end

  // Stage E3: first and last output positions scaled by the stride.
  logic [DimW-1:0]   xl, yl;
  logic [12:0]       px0, px1, py0, py1;
  logic              e3_grid_err;
  logic [CoordW-1:0] e3_ox, e3_oy;
  logic [TileW-1:0]  e3_otw, e3_oth;
  logic [12:0]       e3_px0, e3_px1, e3_py0, e3_py1;

  always_comb begin
    xl  = {1'b0, e2_ox} + {6'b0, e2_otw} - 11'd1;
    yl  = {1'b0, e2_oy} + {6'b0, e2_oth} - 11'd1;
    px0 = {3'b0, e2_ox} * {11'b0, stride};
    py0 = {3'b0, e2_oy} * {11'b0, stride};
    px1 = {2'b0, xl} * {11'b0, stride};
    py1 = {2'b0, yl} * {11'b0, stride};
  end

  always_ff @(posedge clk) begin
    if (en[StE3]) begin
      e3_grid_err <= e2_grid_err;
      e3_ox       <= e2_ox;
      e3_oy       <= e2_oy;
      e3_otw      <= e2_otw;
      e3_oth      <= e2_oth;
      e3_px0      <= px0;
      e3_px1      <= px1;
      e3_py0      <= py0;
      e3_py1      <= py1;
    end
  end

  // Stage E4: apply padding and kernel, clamp to the input tensor, pick the status.
  logic signed [14:0] x0, y0, x1, y1, iw_s, ih_s, span_x, span_y;
  logic               win_bad;
  status_t            st;

  always_comb begin
    iw_s = {4'b0, iw};
    ih_s = {4'b0, ih};
    x0   = {2'b0, e3_px0};
    y0   = {2'b0, e3_py0};
    x0   = x0 - {14'b0, padding[0]};
    y0   = y0 - {14'b0, padding[1]};
    x1   = {2'b0, e3_px1};
    y1   = {2'b0, e3_py1};
    x1   = x1 - {14'b0, padding[0]} + {13'b0, kernel_size};
    y1   = y1 - {14'b0, padding[1]} + {13'b0, kernel_size};
    if (x0 < 0) begin
      x0 = '0;
    end
    if (y0 < 0) begin
      y0 = '0;
    end
    if (x1 > iw_s) begin
      x1 = iw_s;
    end
    if (y1 > ih_s) begin
      y1 = ih_s;
    end
    win_bad = (x1 <= x0) || (y1 <= y0);
    span_x  = x1 - x0;
    span_y  = y1 - y0;
    priority if (hint_bad) begin
      st = StHint;
    end else if (e3_grid_err) begin
      st = StGrid;
    end else if (win_bad) begin
      st = StWindow;
    end else begin
      st = StOk;
    end
  end

  always_ff @(posedge clk) begin
    if (en[StOut]) begin
      status <= st;
      if (st == StOk) begin
        out_x <= e3_ox;
        out_y <= e3_oy;
        out_w <= e3_otw;
        out_h <= e3_oth;
        in_x  <= x0[CoordW-1:0];
        in_y  <= y0[CoordW-1:0];
        in_w  <= span_x[DimW-1:0];
        in_h  <= span_y[DimW-1:0];
      end else begin
        out_x <= '0;
        out_y <= '0;
        out_w <= '0;
        out_h <= '0;
        in_x  <= '0;
        in_y  <= '0;
        in_w  <= '0;
        in_h  <= '0;
      end
    end
  end

  // An empty output slot lets the whole pipeline move.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output stage is empty");

  a_error_zeroes_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != StOk) |->
      (out_w == '0 && out_h == '0 && in_w == '0 && in_h == '0))
    else $error("error word carries nonzero sizes");

  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == StOk) |->
      (out_w != '0 && out_h != '0 && in_w != '0 && in_h != '0))
    else $error("ok word with an empty tile or window");

endmodule
